[hdl/pqecn_pkg.sv]
// shared types and constants of the phantom queue ecn marker
package pqecn_pkg;

    localparam int NUM_PORTS    = 16;
    localparam int PORT_W       = 4;
    localparam int LEN_W        = 28;
    localparam int TIME_W       = 48;
    localparam int BYTES_W      = 24;
    localparam int SIZE_W       = 16;
    localparam int MSG_W        = 3;
    localparam int RATE_FRAC_W  = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CLAMP_FACTOR = 10;

    // sums and products that grow past the field widths
    localparam int SUM_W   = LEN_W + 1;
    localparam int HALF_W  = TIME_W / 2;
    localparam int PP_W    = HALF_W + BYTES_W;
    localparam int PROD_W  = TIME_W + BYTES_W;
    localparam int DELTA_W = PROD_W - RATE_FRAC_W;

    localparam logic [MSG_W-1:0] MSG_REQUEST     = 3'd0;
    localparam logic [MSG_W-1:0] MSG_REPLY       = 3'd1;
    localparam logic [MSG_W-1:0] MSG_GRANT       = 3'd2;
    localparam logic [MSG_W-1:0] MSG_GNT_REQUEST = 3'd3;
    localparam logic [MSG_W-1:0] MSG_OTHER       = 3'd4;

    localparam logic CMD_INGRESS = 1'b0;
    localparam logic CMD_EGRESS  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MARK_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAIN_RATE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EGRESS_THRESHOLD = 2'd2;

    // classified event handed from the front end to the execution side
    typedef struct packed {
        logic [PORT_W-1:0]  port;
        logic               port_ok;
        logic               egress;
        logic               is_data;
        logic [BYTES_W-1:0] addend;
        logic [TIME_W-1:0]  now_ns;
        logic [BYTES_W-1:0] egress_queue_bytes;
    } item_t;

endpackage

[hdl/pqecn_pkt_if.sv]
// packet event channel
interface pqecn_pkt_if;
    import pqecn_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [PORT_W-1:0]  port;
    logic [MSG_W-1:0]   msg_kind;
    logic [BYTES_W-1:0] credit;
    logic [BYTES_W-1:0] unsolicited_credit;
    logic [SIZE_W-1:0]  packet_size;
    logic [TIME_W-1:0]  now_ns;
    logic [BYTES_W-1:0] egress_queue_bytes;

    modport source (
        output valid, cmd, port, msg_kind, credit, unsolicited_credit,
               packet_size, now_ns, egress_queue_bytes,
        input  ready
    );
    modport sink (
        input  valid, cmd, port, msg_kind, credit, unsolicited_credit,
               packet_size, now_ns, egress_queue_bytes,
        output ready
    );
endinterface

[hdl/pqecn_res_if.sv]
// marking result channel
interface pqecn_res_if;
    import pqecn_pkg::*;

    logic             valid;
    logic             ready;
    logic             ce_mark;
    logic [LEN_W-1:0] phantom_length;

    modport source (
        output valid, ce_mark, phantom_length,
        input  ready
    );
    modport sink (
        input  valid, ce_mark, phantom_length,
        output ready
    );
endinterface

[hdl/pqecn_cfg_if.sv]
// register write channel
interface pqecn_cfg_if;
    import pqecn_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTES_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[hdl/phantom_queue_ecn_marker_core.sv]
// top level of the phantom queue ecn marker
// an event taken from the queue is registered, then steps through the read, multiply,
// sum and done states; the done state loads the result once the output register is free
// the execution side handles one event at a time and takes the next only back in idle
// a two-entry queue lets events be taken while a result waits for its transfer
// reset clears all phantom lengths, last-event times and registers to zero
module phantom_queue_ecn_marker_core
    import pqecn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pqecn_pkt_if.sink   pkt,
    pqecn_cfg_if.sink   cfg,
    pqecn_res_if.source res
);

    logic  q_full;
    logic  q_push;
    item_t q_push_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_head;

    pqecn_front u_front (
        .pkt    (pkt),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_push_item)
    );

    pqecn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    pqecn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

[hdl/pqecn_front.sv]
// front end: takes packet events and classifies them for the queue
module pqecn_front
    import pqecn_pkg::*;
(
    pqecn_pkt_if.sink pkt,
    input  logic      q_full,
    output logic      q_push,
    output item_t     q_item
);

    logic grant;
    logic gnt_request;
    logic data_msg;
    logic add_size;

    assign pkt.ready = !q_full;
    assign q_push    = pkt.valid && !q_full;

    assign grant       = (pkt.msg_kind == MSG_GRANT);
    assign gnt_request = (pkt.msg_kind == MSG_GNT_REQUEST);
    assign data_msg    = (pkt.msg_kind == MSG_REQUEST) || (pkt.msg_kind == MSG_REPLY)
                         || gnt_request;
    assign add_size    = grant || gnt_request || (pkt.unsolicited_credit != '0);

    always_comb
    begin
        q_item.port               = pkt.port;
        q_item.port_ok            = (32'(pkt.port) < NUM_PORTS);
        q_item.egress             = (pkt.cmd == CMD_EGRESS);
        q_item.now_ns             = pkt.now_ns;
        q_item.egress_queue_bytes = pkt.egress_queue_bytes;
        unique case (pkt.cmd)
            CMD_INGRESS:
            begin
                q_item.is_data = 1'b0;
                q_item.addend  = grant ? pkt.credit : '0;
            end
            default:
            begin
                q_item.is_data = data_msg;
                q_item.addend  = add_size ? BYTES_W'(pkt.packet_size) : '0;
            end
        endcase
    end

endmodule

[hdl/pqecn_queue.sv]
// short queue between front end and execution side
module pqecn_queue
    import pqecn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (32'(count_reg) == QUEUE_DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/pqecn_back.sv]
// execution side: per-port phantom queue update, drain, marking and result register
module pqecn_back
    import pqecn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pqecn_cfg_if.sink   cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    pqecn_res_if.source res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_DONE
    } state_t;

    state_t              state_reg;
    item_t               item_reg;
    logic [LEN_W-1:0]    phantom_len_reg [NUM_PORTS];
    logic [TIME_W-1:0]   last_time_reg [NUM_PORTS];
    logic [BYTES_W-1:0]  mark_threshold_reg;
    logic [BYTES_W-1:0]  drain_rate_reg;
    logic [BYTES_W-1:0]  egress_threshold_reg;
    logic [SUM_W-1:0]    len_sum_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [PP_W-1:0]     pp_lo_reg;
    logic [PP_W-1:0]     pp_hi_reg;
    logic [DELTA_W-1:0]  delta_reg;
    logic                out_valid_reg;
    logic                out_mark_reg;
    logic [LEN_W-1:0]    out_len_reg;

    logic [TIME_W-1:0]   last_time;
    logic [TIME_W-1:0]   elapsed_next;
    logic [PROD_W-1:0]   product;
    logic [SUM_W-1:0]    len_drained;
    logic [LEN_W-1:0]    clamp_limit;
    logic [LEN_W-1:0]    len_final;
    logic                mark_next;
    logic                slot_free;
    logic                result_load;

    assign cfg.ready   = 1'b1;
    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign slot_free   = !out_valid_reg || res.ready;
    assign result_load = (state_reg == S_DONE) && slot_free;

    assign res.valid          = out_valid_reg;
    assign res.ce_mark        = out_mark_reg;
    assign res.phantom_length = out_len_reg;

    // a stored time of zero means the port never saw egress, so no drain
    assign last_time = last_time_reg[item_reg.port];
    always_comb
    begin
        if (item_reg.egress && (last_time != '0) && (item_reg.now_ns > last_time))
        begin
            elapsed_next = item_reg.now_ns - last_time;
        end
        else
        begin
            elapsed_next = '0;
        end
    end

    // full-width product from the two registered partial products
    assign product = {pp_hi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pp_lo_reg};

    assign len_drained = (delta_reg > DELTA_W'(len_sum_reg)) ?
                         '0 : len_sum_reg - SUM_W'(delta_reg);
    assign clamp_limit = LEN_W'({{(LEN_W-BYTES_W){1'b0}}, mark_threshold_reg}
                         * LEN_W'(CLAMP_FACTOR));
    // mark test sees the length before the clamp
    assign mark_next   = item_reg.is_data && item_reg.port_ok
                         && (len_drained > SUM_W'(mark_threshold_reg))
                         && (item_reg.egress_queue_bytes > egress_threshold_reg);
    assign len_final   = (len_drained < SUM_W'(clamp_limit)) ?
                         LEN_W'(len_drained) : clamp_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            item_reg             <= '0;
            mark_threshold_reg   <= '0;
            drain_rate_reg       <= '0;
            egress_threshold_reg <= '0;
            len_sum_reg          <= '0;
            elapsed_reg          <= '0;
            pp_lo_reg            <= '0;
            pp_hi_reg            <= '0;
            delta_reg            <= '0;
            out_valid_reg        <= 1'b0;
            out_mark_reg         <= 1'b0;
            out_len_reg          <= '0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                phantom_len_reg[i] <= '0;
                last_time_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_MARK_THRESHOLD:
                    begin
                        mark_threshold_reg <= cfg.data;
                    end
                    REG_DRAIN_RATE:
                    begin
                        drain_rate_reg <= cfg.data;
                    end
                    REG_EGRESS_THRESHOLD:
                    begin
                        egress_threshold_reg <= cfg.data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_item;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    len_sum_reg <= SUM_W'(phantom_len_reg[item_reg.port])
                                   + SUM_W'(item_reg.addend);
                    elapsed_reg <= elapsed_next;
                    state_reg   <= S_MUL;
                end
                S_MUL:
                begin
                    pp_lo_reg <= PP_W'(elapsed_reg[HALF_W-1:0]) * PP_W'(drain_rate_reg);
                    pp_hi_reg <= PP_W'(elapsed_reg[TIME_W-1:HALF_W]) * PP_W'(drain_rate_reg);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    delta_reg <= product[PROD_W-1:RATE_FRAC_W];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        if (item_reg.port_ok)
                        begin
                            phantom_len_reg[item_reg.port] <= len_final;
                            if (item_reg.egress)
                            begin
                                last_time_reg[item_reg.port] <= item_reg.now_ns;
                            end
                        end
                        out_mark_reg  <= mark_next;
                        out_len_reg   <= item_reg.port_ok ? len_final : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
